// File: hw/rtl/bma_pkg.sv
// Shared types, codes and constants for the block map allocator.
// Used by bma_div, bma_core and block_map_allocator; depends on nothing.
package bma_pkg;

  localparam int DEF_BLOCK_BYTES = 32;
  localparam int DEF_MAP_ENTRIES = 256;

  localparam int ENTRY_W       = 8;
  localparam int BYTES_W       = 8;
  localparam int OFFSET_W      = 16;
  localparam int GRANT_W       = 13;
  localparam int PERCENT_W     = 7;
  localparam int PERCENT_SCALE = 100;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [BYTES_W-1:0]  request_bytes;
    logic [OFFSET_W-1:0] release_offset;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic [GRANT_W-1:0]   granted_offset;
    logic [PERCENT_W-1:0] usage_percent;
  } rsp_t;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: hw/rtl/bma_div.sv
// Shared constant-division unit: one registered multiply by a scaled reciprocal.
// The caller picks the reciprocal and takes the quotient bits; depends on bma_pkg.
module bma_div
  import bma_pkg::*;
#(
  parameter int NUM_W = 16,
  parameter int RCP_W = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       num,
  input  logic [RCP_W-1:0]       recip,
  output logic                   done,
  output logic [NUM_W+RCP_W-1:0] prod
);

  localparam int MUL_W = NUM_W + RCP_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        prod <= MUL_W'(num) * MUL_W'(recip);
      end
    end
  end

endmodule

// File: hw/rtl/bma_core.sv
// Allocation sequencer: block map memory, scan/mark/clear walks and usage figure.
// Depends on bma_pkg and bma_div.
module bma_core
  import bma_pkg::*;
#(
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int MAP_ENTRIES = DEF_MAP_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res
);

  localparam int IW         = $clog2(MAP_ENTRIES);
  localparam int USED_W     = $clog2(MAP_ENTRIES + 1);
  localparam int BB_W       = $clog2(BLOCK_BYTES + 1);
  localparam int POOL_BYTES = MAP_ENTRIES * BLOCK_BYTES;
  localparam int CMP_W      = max_int(OFFSET_W, $clog2(POOL_BYTES + 1));
  localparam int PROD_W     = IW + BB_W;
  localparam logic [IW-1:0] LAST = IW'(MAP_ENTRIES - 1);

  // Division by a constant d is a multiply by m = ceil(2^(n+k)/d), with
  // k = ceil(log2 d), and a right shift by n+k. It is exact for every
  // numerator below 2^n.
  localparam int WANT_NW = $clog2((1 << BYTES_W) + BLOCK_BYTES - 1);
  localparam int USE_NW  = $clog2(PERCENT_SCALE * MAP_ENTRIES + 1);
  localparam int WANT_SH = WANT_NW + $clog2(BLOCK_BYTES);
  localparam int IDX_SH  = OFFSET_W + $clog2(BLOCK_BYTES);
  localparam int USE_SH  = USE_NW + $clog2(MAP_ENTRIES);
  localparam longint WANT_RCP =
    ((longint'(1) << WANT_SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam longint IDX_RCP =
    ((longint'(1) << IDX_SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  // The usage figure folds the factor of 100 into its reciprocal.
  localparam longint USE_RCP =
    PERCENT_SCALE * (((longint'(1) << USE_SH) + MAP_ENTRIES - 1) / MAP_ENTRIES);
  localparam int NUM_W = max_int(max_int(WANT_NW, OFFSET_W), USED_W);
  localparam int RCP_W = max_int(max_int($clog2(WANT_RCP + 1), $clog2(IDX_RCP + 1)),
                                 $clog2(USE_RCP + 1));
  localparam int MUL_W = NUM_W + RCP_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WANT_DIV, S_SCAN, S_MARK, S_IDX_DIV,
    S_FREE_RD, S_FREE_CNT, S_FREE_CLR, S_USE_GO, S_USE_DIV, S_RESULT
  } state_t;

  state_t                state;
  logic [ENTRY_W-1:0]    map_mem [MAP_ENTRIES];
  logic [ENTRY_W-1:0]    rdata;
  logic [IW-1:0]         iss;
  logic                  iss_live;
  logic                  ev_valid;
  logic [IW-1:0]         ev_pos;
  logic [ENTRY_W-1:0]    want;
  logic [ENTRY_W-1:0]    run;
  logic [ENTRY_W-1:0]    run_next;
  logic [ENTRY_W-1:0]    left;
  logic [USED_W-1:0]     used;
  logic                  ok;
  logic [GRANT_W-1:0]    grant;
  logic [PERCENT_W-1:0]  percent;
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [RCP_W-1:0]      div_rcp;
  logic                  div_done;
  logic [MUL_W-1:0]      div_prod;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [PROD_W-1:0]     grant_prod;

  bma_div #(
    .NUM_W (NUM_W),
    .RCP_W (RCP_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .recip (div_rcp),
    .done  (div_done),
    .prod  (div_prod)
  );

  // Map memory: one write port, one registered read port addressed by the issue pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rdata <= map_mem[iss];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = iss;
    wr_data = '0;
    unique case (state)
      S_CLEAR: wr_en = 1'b1;
      S_MARK: begin
        wr_en   = 1'b1;
        wr_data = want;
      end
      S_FREE_CLR: begin
        wr_en   = ev_valid && (rdata != '0);
        wr_addr = ev_pos;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign run_next   = (rdata == '0) ? run + ENTRY_W'(1) : '0;
  assign grant_prod = PROD_W'(ev_pos) * PROD_W'(BLOCK_BYTES);

  assign req_ready          = (state == S_IDLE);
  assign res_valid          = (state == S_RESULT);
  assign res.status         = ok ? ST_OK : ST_FAIL;
  assign res.granted_offset = grant;
  assign res.usage_percent  = percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      iss       <= '0;
      iss_live  <= 1'b0;
      ev_valid  <= 1'b0;
      used      <= '0;
      div_start <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (iss == LAST) begin
            state <= S_IDLE;
          end else begin
            iss <= iss + IW'(1);
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            grant <= '0;
            if (req.opcode == OP_ALLOC) begin
              if (req.request_bytes == '0) begin
                ok    <= 1'b0;
                state <= S_USE_GO;
              end else begin
                ok        <= 1'b1;
                div_start <= 1'b1;
                div_num   <= NUM_W'(req.request_bytes) + NUM_W'(BLOCK_BYTES - 1);
                div_rcp   <= RCP_W'(WANT_RCP);
                state     <= S_WANT_DIV;
              end
            end else begin
              if (CMP_W'(req.release_offset) >= CMP_W'(POOL_BYTES)) begin
                ok    <= 1'b0;
                state <= S_USE_GO;
              end else begin
                ok        <= 1'b1;
                div_start <= 1'b1;
                div_num   <= NUM_W'(req.release_offset);
                div_rcp   <= RCP_W'(IDX_RCP);
                state     <= S_IDX_DIV;
              end
            end
          end
        end

        S_WANT_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            want     <= div_prod[WANT_SH +: ENTRY_W];
            iss      <= LAST;
            iss_live <= 1'b1;
            ev_valid <= 1'b0;
            run      <= '0;
            state    <= S_SCAN;
          end
        end

        // Reads are issued from the top index down; each entry returned by the
        // registered read port extends or breaks the current free run.
        S_SCAN: begin
          if (ev_valid && (run_next == want)) begin
            iss      <= ev_pos;
            left     <= want;
            grant    <= GRANT_W'(grant_prod);
            iss_live <= 1'b0;
            state    <= S_MARK;
          end else if (ev_valid && (ev_pos == '0)) begin
            ok       <= 1'b0;
            iss_live <= 1'b0;
            state    <= S_USE_GO;
          end else begin
            ev_valid <= iss_live;
            ev_pos   <= iss;
            if (ev_valid) begin
              run <= run_next;
            end
            if (iss_live) begin
              if (iss == '0) begin
                iss_live <= 1'b0;
              end else begin
                iss <= iss - IW'(1);
              end
            end
          end
        end

        S_MARK: begin
          left <= left - ENTRY_W'(1);
          if (left == ENTRY_W'(1)) begin
            used  <= used + USED_W'(want);
            state <= S_USE_GO;
          end else begin
            iss <= iss + IW'(1);
          end
        end

        S_IDX_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            iss   <= div_prod[IDX_SH +: IW];
            state <= S_FREE_RD;
          end
        end

        S_FREE_RD: state <= S_FREE_CNT;

        S_FREE_CNT: begin
          if (rdata == '0) begin
            state <= S_USE_GO;
          end else begin
            left     <= rdata;
            iss_live <= 1'b1;
            ev_valid <= 1'b0;
            state    <= S_FREE_CLR;
          end
        end

        // Reads run ahead by one; an entry that comes back in use is
        // zeroed and taken off the used count.
        S_FREE_CLR: begin
          ev_valid <= iss_live;
          ev_pos   <= iss;
          if (iss_live) begin
            left <= left - ENTRY_W'(1);
            if ((left == ENTRY_W'(1)) || (iss == LAST)) begin
              iss_live <= 1'b0;
            end else begin
              iss <= iss + IW'(1);
            end
          end
          if (ev_valid && (rdata != '0)) begin
            used <= used - USED_W'(1);
          end
          if (!iss_live && !ev_valid) begin
            state <= S_USE_GO;
          end
        end

        S_USE_GO: begin
          div_start <= 1'b1;
          div_num   <= NUM_W'(used);
          div_rcp   <= RCP_W'(USE_RCP);
          state     <= S_USE_DIV;
        end

        S_USE_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            percent <= div_prod[USE_SH +: PERCENT_W];
            state   <= S_RESULT;
          end
        end

        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/block_map_allocator.sv
// Top level of the block map allocator: sequencer plus response register.
// Depends on bma_pkg and bma_core.

// The allocator manages a pool of MAP_ENTRIES blocks of BLOCK_BYTES bytes
// each through a map with one 8-bit entry per block. An allocate transaction
// rounds request_bytes up to whole blocks, scans the map from the top index
// down and claims the first free run long enough, returning its byte offset;
// a free transaction clears as many entries as the map holds at the block of
// release_offset. Every response carries the percentage of map entries in
// use. After reset the block clears the map entry by entry and accepts no
// request until that pass ends. It then handles one request at a time, with
// req_ready low while it works. Every division is by a constant and runs as
// a multiply by a scaled reciprocal on one shared multiplier. An allocate
// scans the map memory one entry per cycle and marks the run one entry per
// cycle. Failures that are caught up front (zero size, offset past the pool)
// do not touch the map. A finished response waits in its own register, so
// the next request is accepted while the previous response has not yet been
// taken.
module block_map_allocator
  import bma_pkg::*;
#(
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int MAP_ENTRIES = DEF_MAP_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic res_valid;
  logic res_ready;
  rsp_t res;

  bma_core #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The response register takes a new result whenever it is empty or its
  // current transaction completes in the same cycle.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> rsp_valid && (rsp == $past(res)))
    else $error("result from the sequencer was not captured");

  a_usage_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.usage_percent <= PERCENT_W'(PERCENT_SCALE)))
    else $error("usage percentage above full scale");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FAIL) |-> (rsp.granted_offset == '0))
    else $error("failed transaction reports a granted offset");
`endif

endmodule

// File: tb/block_map_allocator_checker.sv
// Response checker for the block map allocator: keeps its own copy of the block map,
// predicts each response and compares it with what the block returns.
// Depends on bma_pkg for the transaction types, opcodes and status codes.
module block_map_allocator_checker
  import bma_pkg::*;
#(
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int MAP_ENTRIES = DEF_MAP_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   failures,
  output int   pending
);

  logic [ENTRY_W-1:0] map_copy [MAP_ENTRIES];
  int                 entries_in_use;
  rsp_t               pending_responses [$];

  // Applies one request to the map copy and returns the response it must produce.
  function automatic rsp_t allocate_or_release(input req_t r);
    rsp_t res;
    int   blocks_wanted;
    int   free_run;
    int   first;
    int   span;
    bit   ok;
    logic [GRANT_W-1:0] grant;
    ok    = 1'b0;
    grant = '0;
    if (r.opcode == OP_ALLOC) begin
      if (r.request_bytes != 0) begin
        blocks_wanted = (int'(r.request_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        free_run      = 0;
        for (int idx = MAP_ENTRIES - 1; idx >= 0 && !ok; idx--) begin
          if (map_copy[idx] == 0) free_run++;
          else free_run = 0;
          if (free_run == blocks_wanted) begin
            for (int k = 0; k < blocks_wanted; k++) map_copy[idx + k] = ENTRY_W'(blocks_wanted);
            entries_in_use += blocks_wanted;
            grant = GRANT_W'(idx * BLOCK_BYTES);
            ok    = 1'b1;
          end
        end
      end
    end else if (int'(r.release_offset) < MAP_ENTRIES * BLOCK_BYTES) begin
      first = int'(r.release_offset) / BLOCK_BYTES;
      span  = int'(map_copy[first]);
      for (int k = 0; k < span && first + k < MAP_ENTRIES; k++) begin
        if (map_copy[first + k] != 0) begin
          map_copy[first + k] = '0;
          entries_in_use--;
        end
      end
      ok = 1'b1;
    end
    res.status         = ok ? ST_OK : ST_FAIL;
    res.granted_offset = grant;
    res.usage_percent  = PERCENT_W'(entries_in_use * PERCENT_SCALE / MAP_ENTRIES);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (map_copy[i]) map_copy[i] = '0;
      entries_in_use = 0;
      pending_responses.delete();
      failures = 0;
    end else begin
      // Responses are matched first, so a request taken on the same edge never
      // stands in for a response that had nothing outstanding.
      if (rsp_valid && rsp_ready) begin
        if (pending_responses.size() == 0) begin
          $error("response with no request outstanding: %p", rsp);
          failures++;
        end else begin
          want = pending_responses.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            failures++;
          end
          if (rsp.granted_offset !== want.granted_offset) begin
            $error("granted_offset: expected %0d, actual %0d",
                   want.granted_offset, rsp.granted_offset);
            failures++;
          end
          if (rsp.usage_percent !== want.usage_percent) begin
            $error("usage_percent: expected %0d, actual %0d",
                   want.usage_percent, rsp.usage_percent);
            failures++;
          end
        end
      end
      if (req_valid && req_ready) pending_responses.push_back(allocate_or_release(req));
    end
    pending = pending_responses.size();
  end

endmodule

// File: tb/block_map_allocator_tb.sv
// Top of the block map allocator testbench: clock, reset, request and response traffic.
// Depends on bma_pkg, block_map_allocator and block_map_allocator_checker.
module block_map_allocator_tb;
  import bma_pkg::*;

  localparam int POOL_BYTES    = DEF_MAP_ENTRIES * DEF_BLOCK_BYTES;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SEGMENT_ITEMS = 50;
  // The last stretch of the run goes with no idling on either side.
  localparam int CALM_ITEMS    = 150;
  // This covers one worst-case allocate in flight.
  localparam int SETTLE_CYCLES = 400;
  // Slowest correct run is roughly 1900 transactions, each at worst a full
  // map scan plus the longest response stall and the longest request gap,
  // plus the clearing pass after reset; the limit is several times that.
  localparam int CYCLE_LIMIT   = 3_000_000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int failures;
  int pending;

  // Idling intensity: 0 means none, higher values stall more often. Both the
  // request side and the response side read it; calm switches idling off.
  int idle_level = 1;
  bit calm       = 1'b0;
  int stall_left = 0;
  int unsigned cycles = 0;

  // Offsets of successful allocations, gathered from the response channel so
  // that most free transactions release real regions.
  logic             opcodes_in_flight [$];
  logic [GRANT_W-1:0] live_offsets    [$];

  always #1 clk = ~clk;

  block_map_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  block_map_allocator_checker alloc_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[block_map_allocator] ERROR");
      $finish;
    end
  end

  // The response side stalls in bursts of random length, and not at all
  // once the calm stretch has begun.
  always @(negedge clk) begin
    if (calm) begin
      rsp_ready  <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else if (idle_level > 0 && $urandom_range(0, 7) < idle_level) begin
      rsp_ready  <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : track_grants
    logic op;
    if (!rst) begin
      if (rsp_valid && rsp_ready && opcodes_in_flight.size() > 0) begin
        op = opcodes_in_flight.pop_front();
        if (op == OP_ALLOC && rsp.status == ST_OK) live_offsets.push_back(rsp.granted_offset);
      end
      if (req_valid && req_ready) opcodes_in_flight.push_back(req.opcode);
    end
  end

  // The unused operand of each transaction carries random bits, since the
  // block must ignore it.
  function automatic req_t alloc_request(input logic [BYTES_W-1:0] bytes);
    req_t r;
    r.opcode         = OP_ALLOC;
    r.request_bytes  = bytes;
    r.release_offset = OFFSET_W'($urandom);
    return r;
  endfunction

  function automatic req_t free_request(input logic [OFFSET_W-1:0] offset);
    req_t r;
    r.opcode         = OP_FREE;
    r.request_bytes  = BYTES_W'($urandom);
    r.release_offset = offset;
    return r;
  endfunction

  // Called at a falling edge. An optional gap drops valid first; otherwise
  // valid stays high straight into the next transaction.
  task automatic send_request(input req_t item);
    if (!calm && idle_level > 0 && $urandom_range(0, 7) < idle_level) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    @(negedge clk);
  endtask

  // Holds the request side off until every expected response has come back.
  task automatic drain_responses();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly sizes from the whole range, with zero, exact block multiples and
  // single-block sizes mixed in.
  function automatic logic [BYTES_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick <= 3) return BYTES_W'($urandom_range(1, 7) * DEF_BLOCK_BYTES);
    if (pick <= 5) return BYTES_W'($urandom_range(1, DEF_BLOCK_BYTES));
    return BYTES_W'($urandom_range(1, 255));
  endfunction

  // Mostly the start of a live region, sometimes a byte inside one, and the
  // rest random block starts, random pool bytes, the pool edge and offsets past it.
  function automatic logic [OFFSET_W-1:0] pick_offset();
    int pick;
    int slot;
    logic [OFFSET_W-1:0] off;
    pick = $urandom_range(0, 19);
    if (pick < 12 && live_offsets.size() > 0) begin
      slot = $urandom_range(0, live_offsets.size() - 1);
      off  = OFFSET_W'(live_offsets[slot]);
      live_offsets.delete(slot);
      if (pick < 3) off = off + OFFSET_W'($urandom_range(0, DEF_BLOCK_BYTES - 1));
      return off;
    end
    if (pick < 15) return OFFSET_W'($urandom_range(0, DEF_MAP_ENTRIES - 1) * DEF_BLOCK_BYTES);
    if (pick < 17) return OFFSET_W'($urandom_range(0, POOL_BYTES - 1));
    if (pick == 17) return OFFSET_W'($urandom_range(POOL_BYTES - 1, POOL_BYTES));
    return OFFSET_W'($urandom_range(POOL_BYTES, 65535));
  endfunction

  initial begin : stimulus
    int alloc_pct;
    int sent;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The first allocations land at the top of the map.
    send_request(alloc_request(8'd0));                              // zero size fails
    send_request(alloc_request(8'd1));                              // block 255
    send_request(alloc_request(8'd255));                            // blocks 247..254
    send_request(alloc_request(8'd32));                             // exact fit, block 246
    send_request(alloc_request(8'd33));                             // blocks 244..245
    // Free inside the eight-block run: the count clips at the end of the map
    // and also wipes the neighbouring one-block run.
    send_request(free_request(OFFSET_W'(252 * DEF_BLOCK_BYTES + 5)));
    send_request(free_request(OFFSET_W'(255 * DEF_BLOCK_BYTES)));   // already free
    send_request(free_request(OFFSET_W'(POOL_BYTES)));              // just past the pool
    send_request(free_request(16'hFFFF));                           // far past the pool
    send_request(free_request(OFFSET_W'(POOL_BYTES - 1)));          // last byte of the pool
    send_request(free_request(OFFSET_W'(244 * DEF_BLOCK_BYTES)));   // two-block run
    send_request(alloc_request(8'h80));
    send_request(alloc_request(8'hFF));
    send_request(free_request(16'h0000));                           // first block, free
    send_request(free_request(16'h5555));
    send_request(free_request(16'h1AAA));
    send_request(alloc_request(8'h7F));
    send_request(free_request(16'h0FE0));
    drain_responses();

    // Random part in segments: fill phases drive the map full so that no run
    // fits and allocations reach index 0, drain phases empty it again.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       alloc_pct = 85;
        1:       alloc_pct = 20;
        default: alloc_pct = 50;
      endcase
      idle_level = $urandom_range(0, 3);
      if (sent == 18 * SEGMENT_ITEMS) drain_responses();
      for (int n = 0; n < SEGMENT_ITEMS && sent < RANDOM_ITEMS; n++) begin
        calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
        if ($urandom_range(0, 99) < alloc_pct) send_request(alloc_request(pick_size()));
        else send_request(free_request(pick_offset()));
        sent++;
      end
    end

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("[block_map_allocator] OK");
    end else begin
      $display("[block_map_allocator] ERROR");
    end
    $finish;
  end

endmodule
